FILE: rtl/irpw_pkg.sv
// Shared constants and types for the infrared pulse-width frame decoder.
package irpw_pkg;

	// Capture length limit and the width of the item position counter
	localparam int CAPTURE_MAX = 128;
	localparam int IDX_W       = $clog2(CAPTURE_MAX + 1);

	// Field and register widths
	localparam int DUR_W   = 16;
	localparam int TOL_W   = 6;
	localparam int EXC_W   = 9;
	localparam int PAY_W   = 32;
	localparam int BITS_W  = 7;
	localparam int NOM_W   = 13;
	localparam int BOUND_W = 21;
	localparam int PROD_W  = 23;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCESS    = 2'd2;
	localparam int CFG_DATA_W = EXC_W;

	// Configuration reset values
	localparam logic [TOL_W-1:0] TOL_RESET    = 6'd25;
	localparam logic [EXC_W-1:0] EXCESS_RESET = 9'd100;

	// Nominal durations in microseconds
	localparam logic [NOM_W-1:0] LEAD_MARK_US  = 13'd3000;
	localparam logic [NOM_W-1:0] LEAD_SPACE_US = 13'd6000;
	localparam logic [NOM_W-1:0] SHORT_SYNC_US = 13'd3000;
	localparam logic [NOM_W-1:0] LONG_SYNC_US  = 13'd6000;
	localparam logic [NOM_W-1:0] ONE_MARK_US   = 13'd2000;
	localparam logic [NOM_W-1:0] ZERO_MARK_US  = 13'd1000;
	localparam logic [NOM_W-1:0] PAIR_SPACE_US = 13'd2000;

	// Duration scale applied before comparing against the bounds
	localparam logic [PROD_W-1:0] PCT_SCALE = 23'd100;

	// Header sizes and minimum capture lengths
	localparam logic [IDX_W-1:0] HDR_LONG         = IDX_W'(4);
	localparam logic [IDX_W-1:0] HDR_SHORT        = IDX_W'(2);
	localparam logic [IDX_W-1:0] TAG_MIN_LONG     = IDX_W'(18);
	localparam logic [IDX_W-1:0] BEACON_MIN_LONG  = IDX_W'(14);
	localparam logic [IDX_W-1:0] TAG_MIN_SHORT    = IDX_W'(16);
	localparam logic [IDX_W-1:0] BEACON_MIN_SHORT = IDX_W'(12);
	localparam logic [IDX_W-1:0] CAPTURE_LIMIT    = IDX_W'(CAPTURE_MAX);

	localparam logic [BITS_W-1:0] BITS_SAT = '1;

	// Inclusive window on the scaled duration
	typedef struct packed {
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} window_t;

	// Windows for every nominal the frame checks
	typedef struct packed {
		window_t mark_1000;
		window_t mark_2000;
		window_t mark_3000;
		window_t mark_6000;
		window_t space_2000;
		window_t space_6000;
	} bounds_t;

	// Per-item window hits
	typedef struct packed {
		logic lead_mark;
		logic lead_space;
		logic short_sync;
		logic long_sync;
		logic pair_space;
		logic one_mark;
		logic zero_mark;
	} match_t;

endpackage

FILE: rtl/irpw_bounds.sv
// Configuration registers and precomputed tolerance windows.
module irpw_bounds
	import irpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  long_gap,
	output bounds_t               bounds
);

	logic             long_gap_q;
	logic [TOL_W-1:0] tol_q;
	logic [EXC_W-1:0] excess_q;
	bounds_t          bounds_q;
	logic [7:0]       pct_lo;
	logic [7:0]       pct_hi;
	bounds_t          bounds_d;

	// Take register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_gap_q <= 1'b0;
			tol_q      <= TOL_RESET;
			excess_q   <= EXCESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_GAP:  long_gap_q <= cfg_data[0];
				REG_TOLERANCE: tol_q      <= cfg_data[TOL_W-1:0];
				REG_EXCESS:    excess_q   <= cfg_data[EXC_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic window_t make_window(input logic [NOM_W-1:0] nom,
			input logic [7:0] lo_pct, input logic [7:0] hi_pct);
		window_t w;
		w.lo = BOUND_W'(nom) * BOUND_W'(lo_pct);
		w.hi = BOUND_W'(nom) * BOUND_W'(hi_pct);
		return w;
	endfunction

	// Widen marks and narrow spaces by the excess, then scale by the tolerance
	always_comb begin
		pct_lo = 8'd100 - 8'(tol_q);
		pct_hi = 8'd100 + 8'(tol_q);
		bounds_d.mark_1000  = make_window(ZERO_MARK_US + NOM_W'(excess_q), pct_lo, pct_hi);
		bounds_d.mark_2000  = make_window(ONE_MARK_US + NOM_W'(excess_q), pct_lo, pct_hi);
		bounds_d.mark_3000  = make_window(LEAD_MARK_US + NOM_W'(excess_q), pct_lo, pct_hi);
		bounds_d.mark_6000  = make_window(LONG_SYNC_US + NOM_W'(excess_q), pct_lo, pct_hi);
		bounds_d.space_2000 = make_window(PAIR_SPACE_US - NOM_W'(excess_q), pct_lo, pct_hi);
		bounds_d.space_6000 = make_window(LEAD_SPACE_US - NOM_W'(excess_q), pct_lo, pct_hi);
	end

	// Hold the windows in registers so compares see a short path
	always_ff @(posedge clk) begin
		bounds_q <= bounds_d;
	end

	assign long_gap = long_gap_q;
	assign bounds   = bounds_q;

endmodule

FILE: rtl/irpw_match.sv
// Window compares of one scaled duration against all nominals.
module irpw_match
	import irpw_pkg::*;
(
	input  logic [PROD_W-1:0] prod,
	input  bounds_t           bounds,
	output match_t            hits
);

	function automatic logic in_window(input logic [PROD_W-1:0] v, input window_t w);
		return (v >= PROD_W'(w.lo)) && (v <= PROD_W'(w.hi));
	endfunction

	// Compare against each window; tag and header mark share the 3000 us window
	always_comb begin
		hits.lead_mark  = in_window(prod, bounds.mark_3000);
		hits.lead_space = in_window(prod, bounds.space_6000);
		hits.short_sync = in_window(prod, bounds.mark_3000);
		hits.long_sync  = in_window(prod, bounds.mark_6000);
		hits.pair_space = in_window(prod, bounds.space_2000);
		hits.one_mark   = in_window(prod, bounds.mark_2000);
		hits.zero_mark  = in_window(prod, bounds.mark_1000);
	end

endmodule

FILE: rtl/irpw_frame.sv
// Frame state tracking and the result register.
module irpw_frame
	import irpw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              last,
	input  logic              long_gap,
	input  match_t            hits,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              frame_ok,
	output logic              is_beacon,
	output logic [PAY_W-1:0]  payload,
	output logic [BITS_W-1:0] bit_count
);

	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              failed_q, failed_d;
	logic              beacon_q, beacon_d;
	logic [PAY_W-1:0]  shift_q, shift_d;
	logic [BITS_W-1:0] bits_q, bits_d;
	logic              pend_q, pend_d;
	logic [IDX_W-1:0]  hdr_sz;
	logic [IDX_W-1:0]  min_len;
	logic              ok;

	logic              out_valid_q;
	logic              frame_ok_q;
	logic              is_beacon_q;
	logic [PAY_W-1:0]  payload_q;
	logic [BITS_W-1:0] bit_count_q;

	// Decode the item at the current position and update the capture state
	always_comb begin
		idx_d    = idx_q;
		failed_d = failed_q;
		beacon_d = beacon_q;
		shift_d  = shift_q;
		bits_d   = bits_q;
		pend_d   = pend_q;
		hdr_sz   = long_gap ? HDR_LONG : HDR_SHORT;

		if (idx_q < CAPTURE_LIMIT) begin
			idx_d = idx_q + IDX_W'(1);
			if (long_gap && idx_q == '0) begin
				// leading gap is ignored
			end else if (long_gap && idx_q == IDX_W'(1)) begin
				if (!hits.lead_mark) failed_d = 1'b1;
			end else if (idx_q == hdr_sz - IDX_W'(2)) begin
				if (!hits.lead_space) failed_d = 1'b1;
			end else if (idx_q == hdr_sz - IDX_W'(1)) begin
				if (hits.short_sync) beacon_d = 1'b0;
				else if (hits.long_sync) beacon_d = 1'b1;
				else failed_d = 1'b1;
			end else if (!idx_q[0]) begin
				pend_d = hits.pair_space;
			end else if (!pend_q) begin
				failed_d = 1'b1;
			end else if (hits.one_mark) begin
				shift_d = {shift_q[PAY_W-2:0], 1'b1};
				if (bits_q != BITS_SAT) bits_d = bits_q + BITS_W'(1);
			end else if (hits.zero_mark) begin
				shift_d = {shift_q[PAY_W-2:0], 1'b0};
				if (bits_q != BITS_SAT) bits_d = bits_q + BITS_W'(1);
			end
		end

		// Check the capture length against the tag or beacon minimum
		if (beacon_d) min_len = long_gap ? BEACON_MIN_LONG : BEACON_MIN_SHORT;
		else min_len = long_gap ? TAG_MIN_LONG : TAG_MIN_SHORT;
		ok = !failed_d && (idx_d >= min_len);
	end

	// Advance the capture state; clear it after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			failed_q <= 1'b0;
			beacon_q <= 1'b0;
			shift_q  <= '0;
			bits_q   <= '0;
			pend_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				idx_q    <= '0;
				failed_q <= 1'b0;
				beacon_q <= 1'b0;
				shift_q  <= '0;
				bits_q   <= '0;
				pend_q   <= 1'b0;
			end else begin
				idx_q    <= idx_d;
				failed_q <= failed_d;
				beacon_q <= beacon_d;
				shift_q  <= shift_d;
				bits_q   <= bits_d;
				pend_q   <= pend_d;
			end
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			frame_ok_q  <= ok;
			is_beacon_q <= ok && beacon_d;
			payload_q   <= ok ? shift_d : '0;
			bit_count_q <= ok ? bits_d : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_ok  = frame_ok_q;
	assign is_beacon = is_beacon_q;
	assign payload   = payload_q;
	assign bit_count = bit_count_q;

endmodule

FILE: rtl/ir_pulse_width_frame_decoder.sv
// Top level of the infrared pulse-width frame decoder.
// The last item is registered in the input stage, then its result and out_valid in the result register.
// Throughput: one item per cycle, but the last item of a frame waits in the input
// register while a held result is stalled; items with no result pass it freely.
// Reset: arst_n clears the capture state, both valid flags and restores the
// configuration registers to their reset values.
module ir_pulse_width_frame_decoder
	import irpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DUR_W-1:0]      duration_us,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  frame_ok,
	output logic                  is_beacon,
	output logic [PAY_W-1:0]      payload,
	output logic [BITS_W-1:0]     bit_count
);

	logic              valid_s1;
	logic              last_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              out_free;
	logic              step;
	logic              long_gap;
	bounds_t           bounds;
	match_t            hits;

	// Advance the input stage unless its result has nowhere to go
	assign out_free = !out_valid || !out_stall;
	assign step     = valid_s1 && (out_free || !last_s1);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the request with its duration already scaled to percent units
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			last_s1 <= last_item;
			prod_s1 <= PROD_W'(duration_us) * PCT_SCALE;
		end
	end

	irpw_bounds u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.long_gap  (long_gap),
		.bounds    (bounds)
	);

	irpw_match u_match (
		.prod   (prod_s1),
		.bounds (bounds),
		.hits   (hits)
	);

	irpw_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last      (last_s1),
		.long_gap  (long_gap),
		.hits      (hits),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.frame_ok  (frame_ok),
		.is_beacon (is_beacon),
		.payload   (payload),
		.bit_count (bit_count)
	);

endmodule

FILE: tb/sv/ir_pulse_width_frame_decoder_checker.sv
// Frame checker: tracks the registers, predicts each frame result and compares it.
`timescale 1ns / 100ps

module ir_pulse_width_frame_decoder_checker
	import irpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [DUR_W-1:0]      duration_us,
	input  logic                  last_item,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  frame_ok,
	input  logic                  is_beacon,
	input  logic [PAY_W-1:0]      payload,
	input  logic [BITS_W-1:0]     bit_count,
	output int unsigned           mismatch_count,
	output int unsigned           frames_pending
);

	typedef struct packed {
		logic              ok;
		logic              beacon;
		logic [PAY_W-1:0]  bits_value;
		logic [BITS_W-1:0] bits_total;
	} frame_result_t;

	// Register copy
	logic             long_gap;
	logic [TOL_W-1:0] tol_pct;
	logic [EXC_W-1:0] excess;

	// Capture state
	int unsigned       cap_len;
	logic              cap_failed;
	logic              cap_beacon;
	logic [PAY_W-1:0]  cap_shift;
	logic [BITS_W-1:0] cap_bits;
	logic              cap_space_ok;

	frame_result_t expected_frames[$];

	// Inclusive tolerance window around a nominal, in scaled microseconds
	function automatic logic within_tol(input logic [DUR_W-1:0] d, input int unsigned nom);
		int unsigned scaled;
		int unsigned lo;
		int unsigned hi;
		scaled = 32'(d) * 100;
		lo     = nom * (100 - 32'(tol_pct));
		hi     = nom * (100 + 32'(tol_pct));
		return scaled >= lo && scaled <= hi;
	endfunction

	function automatic logic mark_hit(input logic [DUR_W-1:0] d, input logic [NOM_W-1:0] nom);
		return within_tol(d, 32'(nom) + 32'(excess));
	endfunction

	function automatic logic space_hit(input logic [DUR_W-1:0] d, input logic [NOM_W-1:0] nom);
		return within_tol(d, 32'(nom) - 32'(excess));
	endfunction

	task automatic clear_capture();
		cap_len      = 0;
		cap_failed   = 1'b0;
		cap_beacon   = 1'b0;
		cap_shift    = '0;
		cap_bits     = '0;
		cap_space_ok = 1'b0;
	endtask

	// Advance the capture by one duration; queue a result on the last one
	task automatic take_duration(input logic [DUR_W-1:0] d, input logic lst);
		int unsigned   hdr;
		int unsigned   min_len;
		frame_result_t res;
		hdr = 32'(long_gap ? HDR_LONG : HDR_SHORT);
		// Durations past the capture limit are dropped unchecked
		if (cap_len < CAPTURE_MAX) begin
			if (long_gap && cap_len == 0) begin
				// leading gap carries no information
			end else if (long_gap && cap_len == 1) begin
				if (!mark_hit(d, LEAD_MARK_US))
					cap_failed = 1'b1;
			end else if (cap_len == hdr - 2) begin
				if (!space_hit(d, LEAD_SPACE_US))
					cap_failed = 1'b1;
			end else if (cap_len == hdr - 1) begin
				if (mark_hit(d, SHORT_SYNC_US))
					cap_beacon = 1'b0;
				else if (mark_hit(d, LONG_SYNC_US))
					cap_beacon = 1'b1;
				else
					cap_failed = 1'b1;
			end else if (((cap_len - hdr) & 1) == 0) begin
				cap_space_ok = space_hit(d, PAIR_SPACE_US);
			end else if (!cap_space_ok) begin
				cap_failed = 1'b1;
			end else if (mark_hit(d, ONE_MARK_US)) begin
				cap_shift = {cap_shift[PAY_W-2:0], 1'b1};
				if (cap_bits != BITS_SAT)
					cap_bits++;
			end else if (mark_hit(d, ZERO_MARK_US)) begin
				cap_shift = {cap_shift[PAY_W-2:0], 1'b0};
				if (cap_bits != BITS_SAT)
					cap_bits++;
			end
			cap_len++;
		end
		if (lst) begin
			if (cap_beacon)
				min_len = 32'(long_gap ? BEACON_MIN_LONG : BEACON_MIN_SHORT);
			else
				min_len = 32'(long_gap ? TAG_MIN_LONG : TAG_MIN_SHORT);
			res.ok         = !cap_failed && cap_len >= min_len;
			res.beacon     = res.ok && cap_beacon;
			res.bits_value = res.ok ? cap_shift : '0;
			res.bits_total = res.ok ? cap_bits : '0;
			expected_frames.push_back(res);
			clear_capture();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_result_t want;
		if (!arst_n) begin
			long_gap = 1'b0;
			tol_pct  = TOL_RESET;
			excess   = EXCESS_RESET;
			clear_capture();
			expected_frames.delete();
			mismatch_count = 0;
			frames_pending = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_LONG_GAP:  long_gap = cfg_data[0];
					REG_TOLERANCE: tol_pct  = cfg_data[TOL_W-1:0];
					REG_EXCESS:    excess   = cfg_data[EXC_W-1:0];
					default: ;
				endcase
			end
			// Predict on every accepted request
			if (in_valid && !in_stall)
				take_duration(duration_us, last_item);
			// Compare every accepted result with the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result with no frame outstanding");
					mismatch_count++;
				end else begin
					want = expected_frames.pop_front();
					if (frame_ok !== want.ok) begin
						$error("frame_ok: expected %0d, got %0d", want.ok, frame_ok);
						mismatch_count++;
					end
					if (is_beacon !== want.beacon) begin
						$error("is_beacon: expected %0d, got %0d", want.beacon, is_beacon);
						mismatch_count++;
					end
					if (payload !== want.bits_value) begin
						$error("payload: expected %08h, got %08h", want.bits_value, payload);
						mismatch_count++;
					end
					if (bit_count !== want.bits_total) begin
						$error("bit_count: expected %0d, got %0d", want.bits_total, bit_count);
						mismatch_count++;
					end
				end
			end
			frames_pending = expected_frames.size();
		end
	end

endmodule

FILE: tb/sv/tb_ir_pulse_width_frame_decoder.sv
// Testbench top: clock, reset, frame stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module tb_ir_pulse_width_frame_decoder;
	import irpw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [DUR_W-1:0]      duration_us;
	logic                  last_item;
	logic                  out_valid;
	logic                  out_stall;
	logic                  frame_ok;
	logic                  is_beacon;
	logic [PAY_W-1:0]      payload;
	logic [BITS_W-1:0]     bit_count;

	int unsigned mismatch_count;
	int unsigned frames_pending;

	// Stimulus-side copy of the settings, used to shape durations
	bit          lg_sh  = 1'b0;
	int unsigned tol_sh = 25;
	int unsigned exc_sh = 100;

	int unsigned stim_items  = 0;
	int unsigned cycle_count = 0;
	bit          tx_quiet    = 1'b0;
	bit          rx_quiet    = 1'b0;
	bit          hold_req    = 1'b0;

	ir_pulse_width_frame_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.duration_us (duration_us),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_ok    (frame_ok),
		.is_beacon   (is_beacon),
		.payload     (payload),
		.bit_count   (bit_count)
	);

	ir_pulse_width_frame_decoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.duration_us    (duration_us),
		.last_item      (last_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_ok       (frame_ok),
		.is_beacon      (is_beacon),
		.payload        (payload),
		.bit_count      (bit_count),
		.mismatch_count (mismatch_count),
		.frames_pending (frames_pending)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ir_pulse_width_frame_decoder regression: fail");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int unsigned stall_left;
		int unsigned r;
		bit          hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !rx_quiet) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					stall_left = $urandom_range(1, 3);
				else if (r < 18)
					stall_left = $urandom_range(10, 30);
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sender idle gap: mostly none or short, now and then long
	function automatic int unsigned tx_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Duration inside the tolerance window, edges included
	function automatic logic [DUR_W-1:0] near_duration(input logic [NOM_W-1:0] nom,
			input bit mark);
		int unsigned center;
		int unsigned lo;
		int unsigned hi;
		center = mark ? 32'(nom) + exc_sh : 32'(nom) - exc_sh;
		lo     = (center * (100 - tol_sh) + 99) / 100;
		hi     = center * (100 + tol_sh) / 100;
		case ($urandom_range(0, 9))
			0: return DUR_W'(lo);
			1: return DUR_W'(hi);
			default: return DUR_W'($urandom_range(hi, lo));
		endcase
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_item(input logic [DUR_W-1:0] d, input logic lst);
		int unsigned gap;
		gap = tx_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		duration_us <= d;
		last_item   <= lst;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, drain the results, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_config(input bit lg, input int unsigned tol, input int unsigned exc);
		write_reg(REG_LONG_GAP, 32'(lg));
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_EXCESS, exc);
		lg_sh  = lg;
		tol_sh = tol;
		exc_sh = exc;
	endtask

	// Header, sync and bit pairs; flaws corrupt items at random
	task automatic send_frame(input bit beacon, input int unsigned pairs, input bit trailing,
			input int unsigned flaw_pct, input bit close);
		logic [DUR_W-1:0] seq[$];
		int unsigned      r;
		if (lg_sh) begin
			seq.push_back(DUR_W'($urandom_range(0, 65535)));
			seq.push_back(near_duration(LEAD_MARK_US, 1'b1));
		end
		seq.push_back(near_duration(LEAD_SPACE_US, 1'b0));
		seq.push_back(near_duration(beacon ? LONG_SYNC_US : SHORT_SYNC_US, 1'b1));
		repeat (pairs) begin
			seq.push_back(near_duration(PAIR_SPACE_US, 1'b0));
			r = $urandom_range(0, 19);
			if (r < 9)
				seq.push_back(near_duration(ONE_MARK_US, 1'b1));
			else if (r < 18)
				seq.push_back(near_duration(ZERO_MARK_US, 1'b1));
			else
				seq.push_back(DUR_W'($urandom_range(0, 65535)));
		end
		// unpaired trailing space, any length
		if (trailing)
			seq.push_back(DUR_W'($urandom_range(0, 65535)));
		foreach (seq[i]) begin
			if ($urandom_range(0, 99) < flaw_pct) begin
				if ($urandom_range(0, 1))
					seq[i] = DUR_W'($urandom_range(0, 65535));
				else
					seq[i] = seq[i] ^ (16'd1 << $urandom_range(0, DUR_W - 1));
			end
		end
		foreach (seq[i]) begin
			send_item(seq[i], close && i == seq.size() - 1);
			if (i < CAPTURE_MAX && !(lg_sh && i == 0))
				stim_items++;
		end
	endtask

	// Well-formed frame with random shape; some flawed, a few overflow the capture
	task automatic random_frame(input bit close);
		int unsigned r;
		int unsigned pairs;
		r = $urandom_range(0, 99);
		if (r < 5)
			pairs = $urandom_range(60, 70);
		else if (r < 15)
			pairs = $urandom_range(0, 6);
		else
			pairs = $urandom_range(5, 20);
		send_frame(1'($urandom_range(0, 1)), pairs, $urandom_range(0, 3) == 0,
			($urandom_range(0, 9) < 6) ? 0 : $urandom_range(3, 20), close);
	endtask

	// Raw durations, closed by a last flag
	task automatic send_noise(input int unsigned count);
		for (int unsigned k = 0; k < count; k++) begin
			send_item(DUR_W'($urandom_range(0, 65535)), k == count - 1);
			stim_items++;
		end
	endtask

	initial begin
		int unsigned phase;
		bit          lg_next;
		int unsigned tol_next;
		int unsigned exc_next;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		duration_us = '0;
		last_item   = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: capture ending before sync, field extremes,
		// minimal beacon frame with trailing space, capture left open
		send_item(16'd0, 1'b1);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd0, 1'b1);
		send_frame(1'b1, 5, 1'b1, 0, 1'b1);
		send_frame(1'b0, 3, 1'b0, 0, 1'b0);
		stim_items += 3;

		// Phases: reset tolerance and excess with the long gap, then extreme settings, then random ones
		phase = 0;
		while (stim_items < 450) begin
			wait_quiet();
			case (phase)
				0: begin lg_next = 1'b1; tol_next = 25; exc_next = 100; end
				1: begin lg_next = 1'b0; tol_next = 0;  exc_next = 0;   end
				2: begin lg_next = 1'b1; tol_next = 50; exc_next = 500; end
				3: begin lg_next = 1'b0; tol_next = 50; exc_next = 0;   end
				4: begin lg_next = 1'b1; tol_next = 0;  exc_next = 500; end
				default: begin
					lg_next  = 1'($urandom_range(0, 1));
					tol_next = $urandom_range(0, 50);
					exc_next = $urandom_range(0, 500);
				end
			endcase
			apply_config(lg_next, tol_next, exc_next);
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			// Back-pressure: receiver holds off while requests keep coming
			if (phase == 0) begin
				tx_quiet = 1'b1;
				hold_req = 1'b1;
				repeat (40) begin
					send_item(DUR_W'($urandom_range(0, 65535)), $urandom_range(0, 3) != 0);
					stim_items++;
				end
				send_item(DUR_W'($urandom_range(0, 65535)), 1'b1);
				stim_items++;
				tx_quiet = 1'b0;
			end
			repeat ($urandom_range(3, 5)) random_frame(1'b1);
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(3, 20));
			// Leave a capture open across the next settings change
			if ($urandom_range(0, 4) == 0)
				random_frame(1'b0);
			phase++;
		end

		wait_quiet();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && frames_pending == 0)
			$display("ir_pulse_width_frame_decoder regression: pass");
		else
			$display("ir_pulse_width_frame_decoder regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/irpw_pkg.sv
rtl/irpw_bounds.sv
rtl/irpw_match.sv
rtl/irpw_frame.sv
rtl/ir_pulse_width_frame_decoder.sv
tb/sv/ir_pulse_width_frame_decoder_checker.sv
tb/sv/tb_ir_pulse_width_frame_decoder.sv
